/* sv/fdsfc_pkg.sv */
// Package for the four-digit segment formatter clock.
// Holds the queue entry type, mark and colon codes and the segment tables.
// Used by every module of the block; depends on nothing.
package fdsfc_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [3:0] MARK_MINUS = 4'd10;
    localparam logic [3:0] MARK_BLANK = 4'd11;

    localparam logic signed [15:0] NUM_MIN = -16'sd999;
    localparam logic signed [15:0] NUM_MAX = 16'sd9999;

    localparam logic [5:0] CLOCK_LIMIT = 6'd60;
    localparam logic [6:0] HOURS_MAX   = 7'd99;

    localparam logic [13:0] REC10_MUL   = 14'd6554;
    localparam logic [13:0] REC100_MUL  = 14'd5243;
    localparam logic [14:0] REC1000_MUL = 15'd16778;

    typedef enum logic [1:0] {
        COLON_OFF   = 2'd0,
        COLON_ON    = 2'd1,
        COLON_BLINK = 2'd2
    } t_colon;

    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_SHOW = 1'b1
    } t_func;

    typedef struct packed {
        logic               temp;
        logic signed [15:0] num;
    } t_job;

    typedef logic [3:0][3:0] t_digits;

    function automatic logic [7:0] right_code(input logic [3:0] m);
        logic [7:0] c;
        case (m)
            4'd0:       c = 8'h7E;
            4'd1:       c = 8'h30;
            4'd2:       c = 8'h6D;
            4'd3:       c = 8'h79;
            4'd4:       c = 8'h33;
            4'd5:       c = 8'h5B;
            4'd6:       c = 8'h5F;
            4'd7:       c = 8'h70;
            4'd8:       c = 8'h7F;
            4'd9:       c = 8'h7B;
            MARK_MINUS: c = 8'h01;
            default:    c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] left_code(input logic [3:0] m);
        logic [7:0] c;
        case (m)
            4'd0:    c = 8'h3F;
            4'd1:    c = 8'h18;
            4'd2:    c = 8'h36;
            4'd3:    c = 8'h3C;
            4'd4:    c = 8'h19;
            4'd5:    c = 8'h2D;
            4'd6:    c = 8'h2F;
            4'd7:    c = 8'h38;
            4'd8:    c = 8'h3F;
            4'd9:    c = 8'h3D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] flag_code(input logic [3:0] m);
        logic [7:0] c;
        case (m)
            4'd0, 4'd1, 4'd7: c = 8'h00;
            MARK_BLANK:       c = 8'h00;
            default:          c = 8'h80;
        endcase
        return c;
    endfunction

endpackage

/* sv/four_digit_segment_formatter_clock.sv */
// Top level of the four-digit segment formatter clock.
// Connects front end, queue and back end; depends on fdsfc_pkg.
//
//  Channel  Handshake            Fields
//  input    push / full          i_func, i_value, i_temp_mode
//  result   empty / pop          o_seg_byte4..7, o_time_mark, o_temp_mark, o_colon_mode
//
// One item is taken per cycle while full is low; a tick updates the clock at once
// and gives no result. A show item reaches the result ports through the queue, the three
// back-end stages and the output register; one per cycle while no result stalls.
// Reset clears the clock, the queue and all stage valid bits.
// A stalled result holds the back end, and full rises once the queue fills.
module four_digit_segment_formatter_clock import fdsfc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_func,
    input  logic [15:0] i_value,
    input  logic        i_temp_mode,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_seg_byte4,
    output logic [7:0]  o_seg_byte5,
    output logic [7:0]  o_seg_byte6,
    output logic [7:0]  o_seg_byte7,
    output logic        o_time_mark,
    output logic        o_temp_mark,
    output logic [1:0]  o_colon_mode
);

    logic accept;
    logic job_valid;
    t_job job;
    t_job q_job;
    logic q_empty;
    logic q_take;

    assign accept = push && !full;

    fdsfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_func      (i_func),
        .i_value     (i_value),
        .i_temp_mode (i_temp_mode),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    fdsfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (job_valid),
        .i_wr_job (job),
        .i_rd     (q_take),
        .o_rd_job (q_job),
        .o_full   (full),
        .o_empty  (q_empty)
    );

    fdsfc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (!q_empty),
        .i_job        (q_job),
        .o_job_take   (q_take),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_seg_byte4  (o_seg_byte4),
        .o_seg_byte5  (o_seg_byte5),
        .o_seg_byte6  (o_seg_byte6),
        .o_seg_byte7  (o_seg_byte7),
        .o_time_mark  (o_time_mark),
        .o_temp_mark  (o_temp_mark),
        .o_colon_mode (o_colon_mode)
    );

endmodule

/* sv/fdsfc_front.sv */
// Front end: keeps the elapsed clock and turns show items into queue entries.
// Depends on fdsfc_pkg.
module fdsfc_front import fdsfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_func,
    input  logic [15:0] i_value,
    input  logic        i_temp_mode,
    output logic        o_job_valid,
    output t_job        o_job
);

    logic [5:0] r_seconds, n_seconds;
    logic [5:0] r_minutes, n_minutes;
    logic [6:0] r_hours, n_hours;
    logic [5:0] sec_inc;
    logic [5:0] min_inc;
    logic [13:0] time_num;

    assign sec_inc = r_seconds + 6'd1;
    assign min_inc = r_minutes + 6'd1;

    always_comb begin
        n_seconds = r_seconds;
        n_minutes = r_minutes;
        n_hours   = r_hours;
        if (i_accept && (i_func == FUNC_TICK)) begin
            n_seconds = sec_inc;
            if (sec_inc >= CLOCK_LIMIT) begin
                n_seconds = '0;
                n_minutes = min_inc;
                if (min_inc >= CLOCK_LIMIT) begin
                    n_minutes = '0;
                    n_hours   = (r_hours < HOURS_MAX) ? r_hours + 7'd1 : '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seconds <= '0;
            r_minutes <= '0;
            r_hours   <= '0;
        end else begin
            r_seconds <= n_seconds;
            r_minutes <= n_minutes;
            r_hours   <= n_hours;
        end
    end

    assign time_num = 14'(r_hours) * 14'd100 + 14'(r_minutes);

    assign o_job_valid = i_accept && (i_func == FUNC_SHOW);
    assign o_job.temp  = i_temp_mode;
    assign o_job.num   = i_temp_mode ? $signed(i_value) : $signed({2'b00, time_num});

endmodule

/* sv/fdsfc_queue.sv */
// Short queue of show entries between the front end and the back end.
// Depends on fdsfc_pkg.
module fdsfc_queue import fdsfc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_wr_job,
    input  logic i_rd,
    output t_job o_rd_job,
    output logic o_full,
    output logic o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    t_job            r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            wr_en, rd_en;

    assign o_full   = (r_count == FULL_COUNT);
    assign o_empty  = (r_count == '0);
    assign wr_en    = i_wr && !o_full;
    assign rd_en    = i_rd && !o_empty;
    assign o_rd_job = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* sv/fdsfc_back.sv */
// Back end: clamps, splits into decimal digits and encodes display bytes.
// Three pipeline stages and an output register; depends on fdsfc_pkg.
module fdsfc_back import fdsfc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_job_take,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_seg_byte4,
    output logic [7:0] o_seg_byte5,
    output logic [7:0] o_seg_byte6,
    output logic [7:0] o_seg_byte7,
    output logic       o_time_mark,
    output logic       o_temp_mark,
    output logic [1:0] o_colon_mode
);

    logic        r_v1, r_v2, r_v3, r_vo;
    logic        rdy1, rdy2, rdy3, rdyo;

    logic        r_temp1, r_neg1;
    logic [13:0] r_mag1;
    logic        r_temp2, r_neg2;
    logic [13:0] r_mag2;
    logic [9:0]  r_q1;
    logic [6:0]  r_q2;
    logic [3:0]  r_q3;
    logic        r_temp3, r_neg3;
    logic [2:0]  r_nd3;
    t_digits     r_dig3;

    logic signed [15:0] clamped;
    logic [15:0]        mag_full;
    logic [27:0]        p1, p2, p3;
    logic [13:0]        d0_full;
    logic [9:0]         d1_full;
    logic [6:0]         d2_full;
    logic [2:0]         nd;
    logic [3:0][3:0]    marks;

    assign rdyo = !r_vo || i_pop;
    assign rdy3 = !r_v3 || rdyo;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_job_take = i_job_valid && rdy1;
    assign o_empty = !r_vo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_job_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdyo) r_vo <= r_v3;
        end
    end

    always_comb begin
        clamped = i_job.num;
        if (i_job.num < NUM_MIN) clamped = NUM_MIN;
        if (i_job.num > NUM_MAX) clamped = NUM_MAX;
        mag_full = clamped[15] ? 16'(-clamped) : 16'(clamped);
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_temp1 <= i_job.temp;
            r_neg1  <= clamped[15];
            r_mag1  <= mag_full[13:0];
        end
    end

    assign p1 = 28'(r_mag1) * 28'(REC10_MUL);
    assign p2 = 28'(r_mag1) * 28'(REC100_MUL);
    assign p3 = 28'(r_mag1) * 28'(REC1000_MUL);

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_temp2 <= r_temp1;
            r_neg2  <= r_neg1;
            r_mag2  <= r_mag1;
            r_q1    <= p1[25:16];
            r_q2    <= p2[25:19];
            r_q3    <= p3[27:24];
        end
    end

    always_comb begin
        d0_full = r_mag2 - 14'(r_q1) * 14'd10;
        d1_full = r_q1 - 10'(r_q2) * 10'd10;
        d2_full = r_q2 - 7'(r_q3) * 7'd10;
        if (r_mag2 >= 14'd1000) begin
            nd = 3'd4;
        end else if (r_mag2 >= 14'd100) begin
            nd = 3'd3;
        end else if (r_mag2 >= 14'd10) begin
            nd = 3'd2;
        end else begin
            nd = 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_temp3   <= r_temp2;
            r_neg3    <= r_neg2;
            r_nd3     <= nd;
            r_dig3[0] <= d0_full[3:0];
            r_dig3[1] <= d1_full[3:0];
            r_dig3[2] <= d2_full[3:0];
            r_dig3[3] <= r_q3;
        end
    end

    // Position 7 holds the least significant digit; marks are indexed by position - 4.
    always_comb begin
        for (int p = 0; p < 4; p++) begin
            if ((3'(3 - p) < r_nd3) || !r_temp3) begin
                marks[p] = r_dig3[3 - p];
            end else if ((3'(3 - p) == r_nd3) && r_neg3) begin
                marks[p] = MARK_MINUS;
            end else begin
                marks[p] = MARK_BLANK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdyo && r_v3) begin
            o_seg_byte4  <= right_code(marks[1]) | flag_code(marks[0]);
            o_seg_byte5  <= left_code(marks[0]);
            o_seg_byte6  <= right_code(marks[3]) | flag_code(marks[2]);
            o_seg_byte7  <= left_code(marks[2]);
            o_time_mark  <= !r_temp3;
            o_temp_mark  <= r_temp3;
            o_colon_mode <= r_temp3 ? COLON_OFF : COLON_BLINK;
        end
    end

endmodule
